// ===== rtl/core/suc_pkg.sv =====
// Shared widths, codes, constants and sideband types of the unit-sphere crossing pipeline.
package suc_pkg;

  // Operand and result widths of the Q16.16 datapath.
  localparam int unsigned CW    = 32;          // one coordinate or time
  localparam int unsigned TW    = CW + 1;      // difference of two coordinates
  localparam int unsigned AW    = 66;          // V.V, unsigned
  localparam int unsigned BW    = 66;          // P0.V, signed
  localparam int unsigned PW    = 68;          // operands of the second product row
  localparam int unsigned DW    = 2 * PW;      // B*B and A*C
  localparam int unsigned DKW   = 98;          // bits of a non-negative discriminant
  localparam int unsigned RADW  = DKW + 64;    // radicand D * 2^64
  localparam int unsigned ROOTW = RADW / 2;    // one root bit per cell
  localparam int unsigned REMW  = ROOTW + 2;   // partial remainder of the root
  localparam int unsigned NW    = 100;         // -B * 2^32 -/+ S
  localparam int unsigned NUMW  = TW + NW;     // dt * N
  localparam int unsigned DENW  = AW + 32;     // A * 2^32
  localparam int unsigned QW    = 35;          // quotient bits before the time must saturate

  // Pipeline depth of each multiplier: input, one stage per 32x32 partial product, sign.
  localparam int unsigned LAT_M1 = 2 + ((TW + 31) / 32) * ((TW + 31) / 32);
  localparam int unsigned LAT_M2 = 2 + ((PW + 31) / 32) * ((PW + 31) / 32);
  localparam int unsigned LAT_M3 = 2 + ((TW + 31) / 32) * ((NW + 31) / 32);

  // Radius 1.0 squared in raw units, and the limits of a saturated time.
  localparam logic signed [PW-1:0] RADIUS_SQ = 68'sh0_0000_0001_0000_0000;
  localparam logic signed [CW-1:0] TIME_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] TIME_MIN  = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ST_MISS  = 2'd0,
    ST_HIT   = 2'd1,
    ST_DEGEN = 2'd2
  } status_e;

  // Sideband carried past the first product row.
  typedef struct packed {
    logic signed [CW-1:0] t0;
    logic signed [TW-1:0] dt;
    logic                 degen;
  } side1_t;

  // Sideband carried past the second product row.
  typedef struct packed {
    logic signed [CW-1:0] t0;
    logic signed [TW-1:0] dt;
    logic                 degen;
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
  } side3_t;

  // Sideband carried past the square-root chain.
  typedef struct packed {
    logic signed [CW-1:0] t0;
    logic signed [TW-1:0] dt;
    logic                 degen;
    logic                 miss;
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
  } side4_t;

  // Sideband carried past the third product row.
  typedef struct packed {
    logic signed [CW-1:0] t0;
    logic                 degen;
    logic                 miss;
    logic [AW-1:0]        a;
  } side5_t;

  // Sideband carried past the divider chains.
  typedef struct packed {
    logic signed [CW-1:0] t0;
    logic                 degen;
    logic                 miss;
    logic                 neg_e;
    logic                 neg_x;
    logic                 ovf_e;
    logic                 ovf_x;
  } side6_t;

  // One finished result.
  typedef struct packed {
    status_e              status;
    logic signed [CW-1:0] entry_time;
    logic signed [CW-1:0] exit_time;
  } result_t;

endpackage

// ===== rtl/core/segment_unit_sphere_crossing.sv =====
// Top level: crossing times of a timed segment with the unit sphere, fully pipelined.
//
//   Group   Dir  Bits  Contents (lowest bit first)
//   s_axis  in   256   start_x, start_y, start_z, end_x, end_y, end_z, start_time, end_time
//   m_axis  out  64+2  tdata: entry_time, exit_time; tuser: status
//
// One transaction is taken every cycle while s_axis_tready is high.
// The depth is set by the 81-cell square-root chain and the 35-cell divider chains,
// plus the three rows of 32x32 partial-product multipliers.
// Reset clears the valid bits of the pipeline and the output stage only.
// A stalled output holds its result and a skid register takes one more, after which
// the whole pipeline and s_axis_tready hold until the output drains.
module segment_unit_sphere_crossing (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, start_time, end_time
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_time, exit_time
  output logic [63:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);
  import suc_pkg::*;

  localparam int unsigned L = 1 + LAT_M1 + 1 + LAT_M2 + 1 + ROOTW + 1 + LAT_M3 + 1 + QW + 1;

  // Clamp t0 + floor(n / d) to the Q16.16 range.
  function automatic logic signed [CW-1:0] sat_time(
    input logic signed [CW-1:0] t0,
    input logic [QW-1:0]        q,
    input logic                 rnz,
    input logic                 neg,
    input logic                 ovf
  );
    logic [QW:0]            qa;
    logic signed [QW+1:0]   qs;
    logic signed [QW+2:0]   sum;
    logic signed [CW-1:0]   res;
    qa  = (QW + 1)'(q) + (QW + 1)'(neg & rnz);
    qs  = neg ? -signed'({1'b0, qa}) : signed'({1'b0, qa});
    sum = (QW + 3)'(t0) + (QW + 3)'(qs);
    if (ovf) begin
      res = neg ? TIME_MIN : TIME_MAX;
    end else if (sum > (QW + 3)'(TIME_MAX)) begin
      res = TIME_MAX;
    end else if (sum < (QW + 3)'(TIME_MIN)) begin
      res = TIME_MIN;
    end else begin
      res = sum[CW-1:0];
    end
    return res;
  endfunction

  logic en;
  logic [L-1:0] vld_q;

  // Stage 1: velocity, time span and the degenerate test.
  logic signed [CW-1:0] in_s [3];
  logic signed [CW-1:0] in_e [3];
  logic signed [CW-1:0] p_q  [3];
  logic signed [TW-1:0] v_q  [3];
  side1_t               s1_q;

  for (genvar i = 0; i < 3; i++) begin : g_in
    assign in_s[i] = s_axis_tdata[CW*i +: CW];
    assign in_e[i] = s_axis_tdata[CW*(i+3) +: CW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= in_s[i];
        v_q[i] <= TW'(in_e[i]) - TW'(in_s[i]);
      end
      s1_q.t0    <= signed'(s_axis_tdata[6*CW +: CW]);
      s1_q.dt    <= TW'(signed'(s_axis_tdata[7*CW +: CW])) -
                    TW'(signed'(s_axis_tdata[6*CW +: CW]));
      s1_q.degen <= (s_axis_tdata[7*CW +: CW] == s_axis_tdata[6*CW +: CW]) ||
                    ((in_e[0] == in_s[0]) && (in_e[1] == in_s[1]) && (in_e[2] == in_s[2]));
    end
  end

  // First product row: V.V, P0.V and P0.P0 term by term.
  logic signed [2*TW-1:0] vv [3];
  logic signed [2*TW-1:0] pv [3];
  logic signed [2*TW-1:0] pp [3];
  side1_t                 s1_o;

  for (genvar i = 0; i < 3; i++) begin : g_m1
    suc_mul #(.WA(TW), .WB(TW)) u_vv (
      .clk_i(clk_i), .en_i(en), .a_i(v_q[i]), .b_i(v_q[i]), .p_o(vv[i]));
    suc_mul #(.WA(TW), .WB(TW)) u_pv (
      .clk_i(clk_i), .en_i(en), .a_i(TW'(p_q[i])), .b_i(v_q[i]), .p_o(pv[i]));
    suc_mul #(.WA(TW), .WB(TW)) u_pp (
      .clk_i(clk_i), .en_i(en), .a_i(TW'(p_q[i])), .b_i(TW'(p_q[i])), .p_o(pp[i]));
  end

  suc_delay #(.W($bits(side1_t)), .DEPTH(LAT_M1)) u_d1 (
    .clk_i(clk_i), .en_i(en), .d_i(s1_q), .q_o(s1_o));

  // Stage 2: sums A, B and C.
  logic signed [PW-1:0] a_q, b_q, c_q;
  side1_t               s2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q  <= PW'(vv[0]) + PW'(vv[1]) + PW'(vv[2]);
      b_q  <= PW'(pv[0]) + PW'(pv[1]) + PW'(pv[2]);
      c_q  <= PW'(pp[0]) + PW'(pp[1]) + PW'(pp[2]) - RADIUS_SQ;
      s2_q <= s1_o;
    end
  end

  // Second product row: B*B and A*C.
  logic signed [DW-1:0] bb, ac;
  side3_t               s3_d, s3_o;

  suc_mul #(.WA(PW), .WB(PW)) u_bb (
    .clk_i(clk_i), .en_i(en), .a_i(b_q), .b_i(b_q), .p_o(bb));
  suc_mul #(.WA(PW), .WB(PW)) u_ac (
    .clk_i(clk_i), .en_i(en), .a_i(a_q), .b_i(c_q), .p_o(ac));

  assign s3_d = '{t0: s2_q.t0, dt: s2_q.dt, degen: s2_q.degen,
                  a: AW'(a_q), b: BW'(b_q)};

  suc_delay #(.W($bits(side3_t)), .DEPTH(LAT_M2)) u_d3 (
    .clk_i(clk_i), .en_i(en), .d_i(s3_d), .q_o(s3_o));

  // Stage 3: discriminant, miss test and the radicand D * 2^64.
  logic signed [DW-1:0] disc;
  logic [RADW-1:0]      rad_q;
  side4_t               s4_q, s4_o;

  assign disc = bb - ac;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= {disc[DKW-1:0], 64'b0};
      s4_q  <= '{t0: s3_o.t0, dt: s3_o.dt, degen: s3_o.degen, miss: disc[DW-1],
                 a: s3_o.a, b: s3_o.b};
    end
  end

  // Square-root chain, one root bit per cell.
  logic [RADW-1:0]  rad_w  [ROOTW+1];
  logic [REMW-1:0]  rem_w  [ROOTW+1];
  logic [ROOTW-1:0] root_w [ROOTW+1];

  assign rad_w[0]  = rad_q;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar k = 0; k < ROOTW; k++) begin : g_sqrt
    suc_sqrt_cell u_cell (
      .clk_i(clk_i), .en_i(en),
      .rad_i(rad_w[k]), .rem_i(rem_w[k]), .root_i(root_w[k]),
      .rad_o(rad_w[k+1]), .rem_o(rem_w[k+1]), .root_o(root_w[k+1]));
  end

  suc_delay #(.W($bits(side4_t)), .DEPTH(ROOTW)) u_d4 (
    .clk_i(clk_i), .en_i(en), .d_i(s4_q), .q_o(s4_o));

  // Stage 4: numerators -B*2^32 -/+ S.
  logic signed [NW-1:0] nbs;
  logic signed [NW-1:0] ne_q, nx_q;
  logic signed [TW-1:0] dt4_q;
  side5_t               s5_q, s5_o;

  assign nbs = -(NW'(s4_o.b) <<< 32);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ne_q  <= nbs - NW'(root_w[ROOTW]);
      nx_q  <= nbs + NW'(root_w[ROOTW]);
      dt4_q <= s4_o.dt;
      s5_q  <= '{t0: s4_o.t0, degen: s4_o.degen, miss: s4_o.miss, a: s4_o.a};
    end
  end

  // Third product row: dt times each numerator.
  logic signed [NUMW-1:0] pe, px;

  suc_mul #(.WA(TW), .WB(NW)) u_pe (
    .clk_i(clk_i), .en_i(en), .a_i(dt4_q), .b_i(ne_q), .p_o(pe));
  suc_mul #(.WA(TW), .WB(NW)) u_px (
    .clk_i(clk_i), .en_i(en), .a_i(dt4_q), .b_i(nx_q), .p_o(px));

  suc_delay #(.W($bits(side5_t)), .DEPTH(LAT_M3)) u_d5 (
    .clk_i(clk_i), .en_i(en), .d_i(s5_q), .q_o(s5_o));

  // Stage 5: magnitudes, divisor A * 2^32 and the early overflow test.
  logic [NUMW-1:0] mag_e, mag_x;
  logic [DENW-1:0] den;
  logic [NUMW:0]   lim;
  logic [NUMW-1:0] me_q, mx_q;
  logic [DENW-1:0] den_q;
  side6_t          s6_q, s6_o;

  assign mag_e = pe[NUMW-1] ? NUMW'(-pe) : NUMW'(pe);
  assign mag_x = px[NUMW-1] ? NUMW'(-px) : NUMW'(px);
  assign den   = {s5_o.a, 32'b0};
  assign lim   = (NUMW + 1)'(den) << QW;

  always_ff @(posedge clk_i) begin
    if (en) begin
      me_q  <= mag_e;
      mx_q  <= mag_x;
      den_q <= den;
      s6_q  <= '{t0: s5_o.t0, degen: s5_o.degen, miss: s5_o.miss,
                 neg_e: pe[NUMW-1], neg_x: px[NUMW-1],
                 ovf_e: {1'b0, mag_e} >= lim, ovf_x: {1'b0, mag_x} >= lim};
    end
  end

  // Two divider chains, entry and exit, highest quotient bit first.
  logic [NUMW-1:0] dr_w [2][QW+1];
  logic [DENW-1:0] dd_w [2][QW+1];
  logic [QW-1:0]   dq_w [2][QW+1];

  assign dr_w[0][0] = me_q;
  assign dr_w[1][0] = mx_q;

  for (genvar c = 0; c < 2; c++) begin : g_div
    assign dd_w[c][0] = den_q;
    assign dq_w[c][0] = '0;
    for (genvar g = 0; g < QW; g++) begin : g_cell
      suc_div_cell #(.K(QW - 1 - g)) u_cell (
        .clk_i(clk_i), .en_i(en),
        .r_i(dr_w[c][g]), .d_i(dd_w[c][g]), .q_i(dq_w[c][g]),
        .r_o(dr_w[c][g+1]), .d_o(dd_w[c][g+1]), .q_o(dq_w[c][g+1]));
    end
  end

  suc_delay #(.W($bits(side6_t)), .DEPTH(QW)) u_d6 (
    .clk_i(clk_i), .en_i(en), .d_i(s6_q), .q_o(s6_o));

  // Stage 6: floor rounding, offset by t0, saturation and status.
  result_t fin_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s6_o.degen) begin
        fin_q <= '{status: ST_DEGEN, entry_time: '0, exit_time: '0};
      end else if (s6_o.miss) begin
        fin_q <= '{status: ST_MISS, entry_time: '0, exit_time: '0};
      end else begin
        fin_q <= '{status: ST_HIT,
                   entry_time: sat_time(s6_o.t0, dq_w[0][QW], |dr_w[0][QW],
                                        s6_o.neg_e, s6_o.ovf_e),
                   exit_time:  sat_time(s6_o.t0, dq_w[1][QW], |dr_w[1][QW],
                                        s6_o.neg_x, s6_o.ovf_x)};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], s_axis_tvalid};
    end
  end

  // Output register with one skid entry behind it.
  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  logic    hold;

  assign en   = !skid_vld_q;
  assign hold = out_vld_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (hold) begin
      if (en && vld_q[L-1]) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[L-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold) begin
      if (en && vld_q[L-1]) begin
        skid_q <= fin_q;
      end
    end else if (skid_vld_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= fin_q;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.exit_time, out_q.entry_time};
  assign m_axis_tuser  = out_q.status;

  // The skid entry fills only behind a result that is waiting.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid without a waiting output");

  // No input transaction is taken while the skid entry is full.
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !s_axis_tready)
    else $error("input taken while skid entry is full");

  // Draining the output with a full skid entry leaves a result in place.
  a_skid_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && m_axis_tready && skid_vld_q) |=> (out_vld_q && !skid_vld_q))
    else $error("skid entry lost on drain");

  // A miss or a degenerate segment carries zero times.
  a_zero_times: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_HIT)) |-> (m_axis_tdata == '0))
    else $error("non-zero times without a crossing");

endmodule

// ===== rtl/core/suc_mul.sv =====
// Pipelined signed multiplier built as a chain of 32x32 partial-product cells.
module suc_mul #(
  parameter int unsigned WA = 33,
  parameter int unsigned WB = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int unsigned NA = (WA + 31) / 32;
  localparam int unsigned NB = (WB + 31) / 32;
  localparam int unsigned NS = NA * NB;
  localparam int unsigned XA = NA * 32;
  localparam int unsigned XB = NB * 32;
  localparam int unsigned WP = WA + WB;

  logic [XA-1:0] ma_q  [NS+1];
  logic [XB-1:0] mb_q  [NS+1];
  logic          sg_q  [NS+1];
  logic [WP-1:0] acc_q [NS+1];
  logic signed [WP-1:0] p_q;
  logic [WA-1:0] abs_a;
  logic [WB-1:0] abs_b;

  // Split the operands into magnitude and sign.
  assign abs_a = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
  assign abs_b = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q[0]  <= XA'(abs_a);
      mb_q[0]  <= XB'(abs_b);
      sg_q[0]  <= a_i[WA-1] ^ b_i[WB-1];
      acc_q[0] <= '0;
    end
  end

  // Each cell adds one aligned partial product and hands the operands on.
  for (genvar k = 0; k < NS; k++) begin : g_cell
    localparam int unsigned I = k / NB;
    localparam int unsigned J = k % NB;
    logic [63:0]       pp;
    logic [XA+XB-1:0]  sh;

    assign pp = ma_q[k][I*32 +: 32] * mb_q[k][J*32 +: 32];
    assign sh = (XA + XB)'(pp) << (32 * (I + J));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ma_q[k+1]  <= ma_q[k];
        mb_q[k+1]  <= mb_q[k];
        sg_q[k+1]  <= sg_q[k];
        acc_q[k+1] <= acc_q[k] + WP'(sh);
      end
    end
  end

  // Restore the sign of the product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sg_q[NS] ? -signed'(acc_q[NS]) : signed'(acc_q[NS]);
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/suc_delay.sv =====
// Shift line that keeps sideband data level with a pipelined unit.
module suc_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  // Advance the whole line whenever the pipeline moves.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ===== rtl/core/suc_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit from two radicand bits.
module suc_sqrt_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [suc_pkg::RADW-1:0]   rad_i,
  input  logic [suc_pkg::REMW-1:0]   rem_i,
  input  logic [suc_pkg::ROOTW-1:0]  root_i,
  output logic [suc_pkg::RADW-1:0]   rad_o,
  output logic [suc_pkg::REMW-1:0]   rem_o,
  output logic [suc_pkg::ROOTW-1:0]  root_o
);
  import suc_pkg::*;

  logic [REMW-1:0]  rem2;
  logic [REMW-1:0]  trial;
  logic             ge;
  logic [RADW-1:0]  rad_q;
  logic [REMW-1:0]  rem_q;
  logic [ROOTW-1:0] root_q;

  // Bring down the next bit pair and try 4*root + 1 against the remainder.
  assign rem2  = {rem_i[REMW-3:0], rad_i[RADW-1 -: 2]};
  assign trial = {root_i, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i << 2;
      rem_q  <= ge ? rem2 - trial : rem2;
      root_q <= {root_i[ROOTW-2:0], ge};
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/suc_div_cell.sv =====
// One cell of a restoring divider chain: decides quotient bit K.
module suc_div_cell #(
  parameter int unsigned K = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [suc_pkg::NUMW-1:0]  r_i,
  input  logic [suc_pkg::DENW-1:0]  d_i,
  input  logic [suc_pkg::QW-1:0]    q_i,
  output logic [suc_pkg::NUMW-1:0]  r_o,
  output logic [suc_pkg::DENW-1:0]  d_o,
  output logic [suc_pkg::QW-1:0]    q_o
);
  import suc_pkg::*;

  logic [NUMW:0]   trial;
  logic            ge;
  logic [QW-1:0]   q_d;
  logic [NUMW-1:0] r_q;
  logic [DENW-1:0] d_q;
  logic [QW-1:0]   q_q;

  // Compare the remainder with the divisor weighted by this bit.
  assign trial = (NUMW + 1)'(d_i) << K;
  assign ge    = {1'b0, r_i} >= trial;

  always_comb begin
    q_d    = q_i;
    q_d[K] = ge;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= ge ? r_i - trial[NUMW-1:0] : r_i;
      d_q <= d_i;
      q_q <= q_d;
    end
  end

  assign r_o = r_q;
  assign d_o = d_q;
  assign q_o = q_q;

endmodule
